// ----- src/sha512_pkg.sv -----
// Package: types, constants and round functions of the SHA-512 hash core.
`timescale 1ns / 1ps
`default_nettype none
package sha512_pkg;

    typedef logic [63:0] word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_UPDATE,
        ST_EMIT
    } back_state_t;

    // Padding phase of the back end.
    typedef enum logic [1:0] {
        PAD_NONE,
        PAD_ZERO,
        PAD_HI,
        PAD_LO
    } pad_phase_t;

    // Word kinds passed from the front end to the back end.
    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_FINAL
    } kind_t;

    typedef struct packed {
        word_t      word;
        logic [3:0] nbytes;
        kind_t      kind;
    } req_t;

    localparam int QueueDepth = 4;
    localparam int QueueAw    = 2;
    localparam int Rounds     = 80;

    localparam word_t INIT_HASH [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam word_t ROUND_K [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    function automatic word_t ror(input word_t x, input int n);
        ror = (x >> n) | (x << (64 - n));
    endfunction

    function automatic word_t big_s0(input word_t x);
        big_s0 = ror(x, 28) ^ ror(x, 34) ^ ror(x, 39);
    endfunction

    function automatic word_t big_s1(input word_t x);
        big_s1 = ror(x, 14) ^ ror(x, 18) ^ ror(x, 41);
    endfunction

    function automatic word_t sml_s0(input word_t x);
        sml_s0 = ror(x, 1) ^ ror(x, 8) ^ (x >> 7);
    endfunction

    function automatic word_t sml_s1(input word_t x);
        sml_s1 = ror(x, 19) ^ ror(x, 61) ^ (x >> 6);
    endfunction

endpackage
`default_nettype wire

// ----- src/sha512_if.sv -----
// Interfaces: request channel and digest channel.
`timescale 1ns / 1ps
`default_nettype none
interface sha512_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic        message_end;
    modport source (output valid, data_word, valid_bytes, message_end, input ready);
    modport sink (input valid, data_word, valid_bytes, message_end, output ready);
endinterface

interface sha512_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
    modport source (output valid, digest_word, digest_index, digest_last, input ready);
    modport sink (input valid, digest_word, digest_index, digest_last, output ready);
endinterface
`default_nettype wire

// ----- src/sha512_front.sv -----
// Front end: accepts requests, classifies them and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none
module sha512_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    sha512_in_if.sink            in_ch,
    output sha512_pkg::req_t     q_data,
    output logic                 q_valid,
    input  wire logic            q_pop
);
    sha512_pkg::req_t                   mem_reg [sha512_pkg::QueueDepth];
    logic [sha512_pkg::QueueAw-1:0]     wr_reg, rd_reg;
    logic [sha512_pkg::QueueAw:0]       cnt_reg;
    sha512_pkg::req_t                   req;
    logic                               push;
    logic [3:0]                         nb;

    always_comb
    begin
        if (!in_ch.message_end)
            nb = 4'd8;
        else if (in_ch.valid_bytes > 4'd8)
            nb = 4'd8;
        else
            nb = in_ch.valid_bytes;
        req.word   = in_ch.data_word;
        req.nbytes = nb;
        req.kind   = in_ch.message_end ? sha512_pkg::KIND_FINAL : sha512_pkg::KIND_DATA;
    end

    assign in_ch.ready = (cnt_reg != (sha512_pkg::QueueAw+1)'(sha512_pkg::QueueDepth));
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (cnt_reg != '0);
    assign q_data      = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (q_pop)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (push ? 1'b1 : 1'b0) - (q_pop ? 1'b1 : 1'b0);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == (sha512_pkg::QueueAw+1)'(sha512_pkg::QueueDepth)) |-> !push)
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("queue underflow");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("count mismatch");
endmodule
`default_nettype wire

// ----- src/sha512_back.sv -----
// Back end: block buffer, padding, 80-round compression and digest output.
`timescale 1ns / 1ps
`default_nettype none
module sha512_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sha512_pkg::req_t  q_data,
    input  wire logic              q_valid,
    output logic                   q_pop,
    sha512_out_if.source           out_ch
);
    typedef sha512_pkg::word_t word_t;

    sha512_pkg::back_state_t state_reg, state_next;
    word_t       hv_reg [8];
    word_t       wv_reg [8];
    word_t       win_reg [16];
    logic [3:0]  pos_reg;
    logic [6:0]  rnd_reg;
    logic [127:0] bits_reg;
    // pend_reg: 0x80 word still owed after a full final word
    sha512_pkg::pad_phase_t pad_reg;
    logic        pend_reg;
    logic [2:0]  oidx_reg;
    logic        done_reg;

    logic        take_word;
    word_t       push_val;
    logic        push_en;
    word_t       fin_word;
    word_t       mask;
    word_t       w_t, t1, t2, sched;

    always_comb
    begin
        mask = (q_data.nbytes == 4'd0) ? 64'd0 : (~64'd0 << (7'd64 - {q_data.nbytes, 3'b000}));
        fin_word = (q_data.word & mask) |
            (q_data.nbytes == 4'd8 ? 64'd0 : (64'h80 << (6'd56 - {q_data.nbytes[2:0], 3'b000})));
    end

    // push source selection while idle
    always_comb
    begin
        push_en   = 1'b0;
        push_val  = '0;
        take_word = 1'b0;
        if (state_reg == sha512_pkg::ST_IDLE)
        begin
            if (pend_reg)
            begin
                push_en  = 1'b1;
                push_val = 64'h8000000000000000;
            end
            else if (pad_reg == sha512_pkg::PAD_ZERO)
            begin
                push_en = 1'b1;
            end
            else if (pad_reg == sha512_pkg::PAD_HI)
            begin
                push_en  = 1'b1;
                push_val = bits_reg[127:64];
            end
            else if (pad_reg == sha512_pkg::PAD_LO)
            begin
                push_en  = 1'b1;
                push_val = bits_reg[63:0];
            end
            else if (q_valid)
            begin
                push_en   = 1'b1;
                take_word = 1'b1;
                push_val  = (q_data.kind == sha512_pkg::KIND_FINAL) ? fin_word : q_data.word;
            end
        end
    end
    assign q_pop = take_word;

    always_comb
    begin
        sched = sha512_pkg::sml_s1(win_reg[14]) + win_reg[9] +
                sha512_pkg::sml_s0(win_reg[1]) + win_reg[0];
        w_t = (rnd_reg < 7'd16) ? win_reg[0] : sched;
        t1 = wv_reg[7] + sha512_pkg::big_s1(wv_reg[4]) +
             ((wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6])) +
             sha512_pkg::ROUND_K[rnd_reg] + w_t;
        t2 = sha512_pkg::big_s0(wv_reg[0]) +
             ((wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2]) ^ (wv_reg[1] & wv_reg[2]));
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sha512_pkg::ST_IDLE:
                if (push_en && pos_reg == 4'd15)
                    state_next = sha512_pkg::ST_ROUND;
            sha512_pkg::ST_ROUND:
                if (rnd_reg == 7'(sha512_pkg::Rounds - 1))
                    state_next = sha512_pkg::ST_UPDATE;
            sha512_pkg::ST_UPDATE:
                state_next = (pad_reg == sha512_pkg::PAD_NONE && done_reg) ?
                             sha512_pkg::ST_EMIT : sha512_pkg::ST_IDLE;
            sha512_pkg::ST_EMIT:
                if (out_ch.ready && oidx_reg == 3'd7)
                    state_next = sha512_pkg::ST_IDLE;
            default:
                state_next = sha512_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_ch.valid        = (state_reg == sha512_pkg::ST_EMIT);
        out_ch.digest_word  = hv_reg[oidx_reg];
        out_ch.digest_index = oidx_reg;
        out_ch.digest_last  = (oidx_reg == 3'd7);
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
            win_reg[pos_reg] <= push_val;
        if (state_reg == sha512_pkg::ST_IDLE && push_en && pos_reg == 4'd15)
            wv_reg <= hv_reg;
        if (state_reg == sha512_pkg::ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
                win_reg[i] <= win_reg[i+1];
            win_reg[15] <= w_t;
            wv_reg[7] <= wv_reg[6];
            wv_reg[6] <= wv_reg[5];
            wv_reg[5] <= wv_reg[4];
            wv_reg[4] <= wv_reg[3] + t1;
            wv_reg[3] <= wv_reg[2];
            wv_reg[2] <= wv_reg[1];
            wv_reg[1] <= wv_reg[0];
            wv_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha512_pkg::ST_IDLE;
            hv_reg    <= sha512_pkg::INIT_HASH;
            pos_reg   <= '0;
            rnd_reg   <= '0;
            bits_reg  <= '0;
            pad_reg   <= sha512_pkg::PAD_NONE;
            pend_reg  <= 1'b0;
            oidx_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (push_en)
                pos_reg <= pos_reg + 1'b1;
            if (take_word)
            begin
                bits_reg <= bits_reg + {121'd0, q_data.nbytes, 3'b000};
                if (q_data.kind == sha512_pkg::KIND_FINAL)
                begin
                    pend_reg <= (q_data.nbytes == 4'd8);
                    pad_reg  <= (q_data.nbytes != 4'd8 && pos_reg == 4'd13) ?
                                sha512_pkg::PAD_HI : sha512_pkg::PAD_ZERO;
                end
            end
            if (pend_reg && push_en)
            begin
                pend_reg <= 1'b0;
                if (pos_reg == 4'd13)
                    pad_reg <= sha512_pkg::PAD_HI;
            end
            else if (pad_reg == sha512_pkg::PAD_ZERO && push_en &&
                     state_reg == sha512_pkg::ST_IDLE && pos_reg == 4'd13)
                pad_reg <= sha512_pkg::PAD_HI;
            else if (pad_reg == sha512_pkg::PAD_HI && push_en)
                pad_reg <= sha512_pkg::PAD_LO;
            else if (pad_reg == sha512_pkg::PAD_LO && push_en)
            begin
                pad_reg  <= sha512_pkg::PAD_NONE;
                done_reg <= 1'b1;
            end
            if (state_reg == sha512_pkg::ST_ROUND)
                rnd_reg <= (rnd_reg == 7'(sha512_pkg::Rounds - 1)) ? 7'd0 : rnd_reg + 1'b1;
            if (state_reg == sha512_pkg::ST_UPDATE)
                for (int i = 0; i < 8; i++)
                    hv_reg[i] <= hv_reg[i] + wv_reg[i];
            if (state_reg == sha512_pkg::ST_EMIT && out_ch.ready)
            begin
                oidx_reg <= oidx_reg + 1'b1;
                if (oidx_reg == 3'd7)
                begin
                    hv_reg   <= sha512_pkg::INIT_HASH;
                    bits_reg <= '0;
                    done_reg <= 1'b0;
                end
            end
        end
    end

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == sha512_pkg::ST_IDLE)) else $error("pop while busy");
    a_emit_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> (oidx_reg == 3'd0)) else $error("emit index");
    a_round_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha512_pkg::ST_IDLE) |-> (rnd_reg == 7'd0)) else $error("round count");
endmodule
`default_nettype wire

// ----- src/sha512_hash_core.sv -----
// SHA-512 hash core: request channel in, eight-word digest channel out.
// Usage:
//   in_ch carries 64-bit big-endian message words. Every word is full
//   except the one flagged message_end, which holds valid_bytes upper bytes.
//   out_ch returns the digest, H0 first, digest_last on index 7.
// Operation:
//   A front queue of four requests absorbs words while the back end
//   compresses. Each 16-word block is loaded word by word, then run
//   through 80 rounds (one round per cycle in a single round unit) and
//   an update of the hash values. A final word adds up to one extra
//   block of padding, then the eight digest words are output.
// Reset:
//   rst_n clears queue, counters and restores the initial hash values.
// Stall:
//   While out_ch.ready is low the current digest word is held; the front
//   queue keeps taking requests until it is full.
`timescale 1ns / 1ps
`default_nettype none
module sha512_hash_core (
    input  wire logic    clk,
    input  wire logic    rst_n,
    sha512_in_if.sink    in_ch,
    sha512_out_if.source out_ch
);
    sha512_pkg::req_t q_data;
    logic             q_valid;
    logic             q_pop;

    sha512_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_data  (q_data),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    sha512_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_data),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );
endmodule
`default_nettype wire
